/* hw/rtl/erm_pkg.sv */
// ----------------------------------------------------------------------------
// erm_pkg: shared constants, types and functions
// fixed-point constants, atan table and queue item types for the rotation block
// ----------------------------------------------------------------------------
`default_nettype none

package erm_pkg;

	localparam int TRIG_STAGES = 16;   // cordic rotation stages, 8..24
	localparam int ANG_W       = 16;   // input angle, Q4.12
	localparam int ENT_W       = 16;   // sine, cosine and matrix entries, Q2.14
	localparam int RAW_W       = 35;   // angle in Q.30 before folding
	localparam int CW          = 34;   // cordic datapath word
	localparam int PW          = 30;   // Q.28 partial products of two entries
	localparam int QW          = 45;   // Q.42 matrix sums
	localparam int MIDQ_DEPTH  = 4;
	localparam int MIDQ_AW     = $clog2(MIDQ_DEPTH);
	localparam int OUTQ_DEPTH  = 2;
	localparam int NVALID      = TRIG_STAGES + 4;

	localparam logic signed [RAW_W-1:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [RAW_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
	localparam logic signed [RAW_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [CW-1:0]    GAIN_Q30    = 34'sd652032874;
	localparam logic signed [QW-1:0]    ONE_Q14     = 45'sd16384;

	typedef struct packed {
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [CW-1:0] az;
		logic                 nx;
		logic                 ny;
		logic                 nz;
	} erm_item_t;

	typedef struct packed {
		logic signed [ENT_W-1:0] e00;
		logic signed [ENT_W-1:0] e01;
		logic signed [ENT_W-1:0] e02;
		logic signed [ENT_W-1:0] e10;
		logic signed [ENT_W-1:0] e11;
		logic signed [ENT_W-1:0] e12;
		logic signed [ENT_W-1:0] e20;
		logic signed [ENT_W-1:0] e21;
		logic signed [ENT_W-1:0] e22;
	} erm_mat_t;

	// truncated atan(2^-i) in Q.30
	function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
		logic signed [CW-1:0] r;
		begin
			case (i)
				5'd0:  r = 34'sh3243F6A8;
				5'd1:  r = 34'sh1DAC6705;
				5'd2:  r = 34'sh0FADBAFC;
				5'd3:  r = 34'sh07F56EA6;
				5'd4:  r = 34'sh03FEAB76;
				5'd5:  r = 34'sh01FFD55B;
				5'd6:  r = 34'sh00FFFAAA;
				5'd7:  r = 34'sh007FFF55;
				5'd8:  r = 34'sh003FFFEA;
				5'd9:  r = 34'sh001FFFFD;
				5'd10: r = 34'sh000FFFFF;
				5'd11: r = 34'sh0007FFFF;
				5'd12: r = 34'sh0003FFFF;
				5'd13: r = 34'sh0001FFFF;
				5'd14: r = 34'sh0000FFFF;
				5'd15: r = 34'sh00007FFF;
				5'd16: r = 34'sh00003FFF;
				5'd17: r = 34'sh00001FFF;
				5'd18: r = 34'sh00000FFF;
				5'd19: r = 34'sh000007FF;
				5'd20: r = 34'sh000003FF;
				5'd21: r = 34'sh000001FF;
				5'd22: r = 34'sh000000FF;
				5'd23: r = 34'sh0000007F;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	// clamp to plus or minus one in Q2.14
	function automatic logic signed [ENT_W-1:0] sat_one(input logic signed [QW-1:0] v);
		logic signed [ENT_W-1:0] r;
		begin
			if (v > ONE_Q14)
				r = ENT_W'(ONE_Q14);
			else if (v < -ONE_Q14)
				r = ENT_W'(-ONE_Q14);
			else
				r = v[ENT_W-1:0];
			return r;
		end
	endfunction

	// round Q.42 to Q.14, then clamp
	function automatic logic signed [ENT_W-1:0] finish(input logic signed [QW-1:0] v);
		logic signed [QW-1:0] t;
		begin
			t = (v + (QW'(1) <<< 27)) >>> 28;
			return sat_one(t);
		end
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/euler_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// euler_rotation_matrix: rotation matrix Rx*Ry*Rz from three angles
// cordic sine and cosine per angle, then the nine Q2.14 matrix entries
// ----------------------------------------------------------------------------
// Give three angles in Q4.12 radians; the block returns the nine entries of
// Rx*Ry*Rz in Q2.14, each clamped to plus or minus one, one result item per
// input item, in order. Any 16-bit angle is valid. Both sides look like a
// queue: push/full on input, empty/pop on output. One item is taken every
// clock cycle when the output side keeps popping; the cordic chain has one
// registered rotation stage per iteration. A four-item queue sits between the
// folding front and the cordic back, and a two-item result queue lets the
// input keep flowing while a finished item waits to be popped.
`default_nettype none

module euler_rotation_matrix import erm_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic signed [ANG_W-1:0] angle_x,
	input  wire logic signed [ANG_W-1:0] angle_y,
	input  wire logic signed [ANG_W-1:0] angle_z,
	output logic                         empty,
	input  wire logic                    pop,
	output logic signed [ENT_W-1:0]      row0_col0,
	output logic signed [ENT_W-1:0]      row0_col1,
	output logic signed [ENT_W-1:0]      row0_col2,
	output logic signed [ENT_W-1:0]      row1_col0,
	output logic signed [ENT_W-1:0]      row1_col1,
	output logic signed [ENT_W-1:0]      row1_col2,
	output logic signed [ENT_W-1:0]      row2_col0,
	output logic signed [ENT_W-1:0]      row2_col1,
	output logic signed [ENT_W-1:0]      row2_col2
);

	// front to queue
	logic      mq_push;
	logic      mq_full;
	erm_item_t mq_wdata;
	// queue to back
	logic      mq_pop;
	logic      mq_empty;
	erm_item_t mq_rdata;
	erm_mat_t  mat;

	// angle folding, two stages
	erm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.angle_x (angle_x),
		.angle_y (angle_y),
		.angle_z (angle_z),
		.q_full  (mq_full),
		.q_push  (mq_push),
		.q_data  (mq_wdata)
	);

	// decoupling queue
	erm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mq_push),
		.wdata  (mq_wdata),
		.full   (mq_full),
		.rd     (mq_pop),
		.rdata  (mq_rdata),
		.empty  (mq_empty)
	);

	// cordic lanes, matrix products, result queue
	erm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (mq_empty),
		.q_data  (mq_rdata),
		.q_pop   (mq_pop),
		.pop     (pop),
		.empty   (empty),
		.mat     (mat)
	);

	assign row0_col0 = mat.e00;
	assign row0_col1 = mat.e01;
	assign row0_col2 = mat.e02;
	assign row1_col0 = mat.e10;
	assign row1_col1 = mat.e11;
	assign row1_col2 = mat.e12;
	assign row2_col0 = mat.e20;
	assign row2_col1 = mat.e21;
	assign row2_col2 = mat.e22;

endmodule

`default_nettype wire

/* hw/rtl/erm_front.sv */
// ----------------------------------------------------------------------------
// erm_front: angle intake and range folding
// wraps each angle into [-pi, pi], then folds into [-pi/2, pi/2] with a cosine flip
// ----------------------------------------------------------------------------
`default_nettype none

module erm_front import erm_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic signed [ANG_W-1:0] angle_x,
	input  wire logic signed [ANG_W-1:0] angle_y,
	input  wire logic signed [ANG_W-1:0] angle_z,
	input  wire logic                    q_full,
	output logic                         q_push,
	output erm_item_t                    q_data
);

	logic                    adv;
	logic                    take;
	logic                    v_s1;
	logic                    v_s2;
	logic signed [ANG_W-1:0] ang [3];
	logic signed [RAW_W-1:0] wrap_d [3];
	logic signed [RAW_W-1:0] wrap_s1 [3];
	logic signed [CW-1:0]    fold_d [3];
	logic                    neg_d [3];
	logic signed [CW-1:0]    fold_s2 [3];
	logic                    neg_s2 [3];

	assign adv  = !(v_s2 && q_full);
	assign full = !adv;
	assign take = push && adv;

	assign ang[0] = angle_x;
	assign ang[1] = angle_y;
	assign ang[2] = angle_z;

	always_comb begin
		logic signed [RAW_W-1:0] a;
		for (int l = 0; l < 3; l++) begin
			a = RAW_W'($signed({ang[l], 18'b0}));
			if (a > PI_Q30)
				wrap_d[l] = a - TWO_PI_Q30;
			else if (a < -PI_Q30)
				wrap_d[l] = a + TWO_PI_Q30;
			else
				wrap_d[l] = a;
		end
	end

	always_comb begin
		logic signed [RAW_W-1:0] w;
		for (int l = 0; l < 3; l++) begin
			w = wrap_s1[l];
			if (w > HALF_PI_Q30) begin
				fold_d[l] = CW'(PI_Q30 - w);
				neg_d[l]  = 1'b1;
			end else if (w < -HALF_PI_Q30) begin
				fold_d[l] = CW'(-PI_Q30 - w);
				neg_d[l]  = 1'b1;
			end else begin
				fold_d[l] = CW'(w);
				neg_d[l]  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 3; l++) begin
				wrap_s1[l] <= wrap_d[l];
				fold_s2[l] <= fold_d[l];
				neg_s2[l]  <= neg_d[l];
			end
		end
	end

	assign q_push    = v_s2 && !q_full;
	assign q_data.ax = fold_s2[0];
	assign q_data.ay = fold_s2[1];
	assign q_data.az = fold_s2[2];
	assign q_data.nx = neg_s2[0];
	assign q_data.ny = neg_s2[1];
	assign q_data.nz = neg_s2[2];

endmodule

`default_nettype wire

/* hw/rtl/erm_fifo.sv */
// ----------------------------------------------------------------------------
// erm_fifo: queue between front and back
// small first-in first-out buffer of folded angle items
// ----------------------------------------------------------------------------
`default_nettype none

module erm_fifo import erm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr,
	input  wire erm_item_t wdata,
	output logic           full,
	input  wire logic      rd,
	output erm_item_t      rdata,
	output logic           empty
);

	erm_item_t            mem_q [MIDQ_DEPTH];
	logic [MIDQ_AW-1:0]   wp_q;
	logic [MIDQ_AW-1:0]   rp_q;
	logic [MIDQ_AW:0]     cnt_q;
	logic                 do_wr;
	logic                 do_rd;

	assign full  = (cnt_q == (MIDQ_AW+1)'(MIDQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= wp_q + 1'b1;
			if (do_rd)
				rp_q <= rp_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/erm_back.sv */
// ----------------------------------------------------------------------------
// erm_back: cordic lanes and matrix product pipeline
// three cordic lanes, rounding, two product stages and a result queue
// ----------------------------------------------------------------------------
`default_nettype none

module erm_back import erm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      q_empty,
	input  wire erm_item_t q_data,
	output logic           q_pop,
	input  wire logic      pop,
	output logic           empty,
	output erm_mat_t       mat
);

	localparam int LAST = NVALID - 1;

	logic                    adv;
	logic [NVALID-1:0]       v_q;
	logic                    opush;
	logic                    odo_pop;
	logic [1:0]              ocnt_q;
	logic                    owp_q;
	logic                    orp_q;
	erm_mat_t                obuf_q [OUTQ_DEPTH];
	erm_mat_t                res_d;

	logic signed [CW-1:0]    x_s [TRIG_STAGES+1][3];
	logic signed [CW-1:0]    y_s [TRIG_STAGES+1][3];
	logic signed [CW-1:0]    z_s [TRIG_STAGES+1][3];
	logic [2:0]              n_s [TRIG_STAGES+1];

	logic signed [ENT_W-1:0] s_d [3];
	logic signed [ENT_W-1:0] c_d [3];
	logic signed [ENT_W-1:0] s_r [3];
	logic signed [ENT_W-1:0] c_r [3];

	logic signed [PW-1:0]    a0_d [3];
	logic signed [PW-1:0]    a1_d [3];
	logic signed [PW-1:0]    a2_d [3];
	logic signed [PW-1:0]    a0_p1 [3];
	logic signed [PW-1:0]    a1_p1 [3];
	logic signed [PW-1:0]    a2_p1 [3];
	logic signed [ENT_W-1:0] sz_p1;
	logic signed [ENT_W-1:0] cz_p1;

	logic signed [QW-1:0]    t_p2 [3][4];
	logic signed [PW-1:0]    a2_p2 [3];

	assign adv     = !(v_q[LAST] && (ocnt_q == 2'd2));
	assign q_pop   = adv && !q_empty;
	assign opush   = v_q[LAST] && adv;
	assign empty   = (ocnt_q == 2'd0);
	assign odo_pop = pop && !empty;
	assign mat     = obuf_q[orp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (adv)
			v_q <= {v_q[NVALID-2:0], !q_empty};
	end

	// cordic entry
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 3; l++) begin
				x_s[0][l] <= GAIN_Q30;
				y_s[0][l] <= '0;
			end
			z_s[0][0] <= q_data.ax;
			z_s[0][1] <= q_data.ay;
			z_s[0][2] <= q_data.az;
			n_s[0]    <= {q_data.nz, q_data.ny, q_data.nx};
		end
	end

	for (genvar k = 0; k < TRIG_STAGES; k++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < 3; l++) begin
					if (z_s[k][l] >= 0) begin
						x_s[k+1][l] <= x_s[k][l] - (y_s[k][l] >>> k);
						y_s[k+1][l] <= y_s[k][l] + (x_s[k][l] >>> k);
						z_s[k+1][l] <= z_s[k][l] - atan_q30(5'(k));
					end else begin
						x_s[k+1][l] <= x_s[k][l] + (y_s[k][l] >>> k);
						y_s[k+1][l] <= y_s[k][l] - (x_s[k][l] >>> k);
						z_s[k+1][l] <= z_s[k][l] + atan_q30(5'(k));
					end
				end
				n_s[k+1] <= n_s[k];
			end
		end
	end

	// round to Q.14, clamp, apply the cosine flip
	always_comb begin
		logic signed [CW-1:0]    xr;
		logic signed [CW-1:0]    yr;
		logic signed [ENT_W-1:0] cs;
		for (int l = 0; l < 3; l++) begin
			xr     = (x_s[TRIG_STAGES][l] + CW'(32768)) >>> 16;
			yr     = (y_s[TRIG_STAGES][l] + CW'(32768)) >>> 16;
			cs     = sat_one(QW'(xr));
			c_d[l] = n_s[TRIG_STAGES][l] ? -cs : cs;
			s_d[l] = sat_one(QW'(yr));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 3; l++) begin
				s_r[l] <= s_d[l];
				c_r[l] <= c_d[l];
			end
		end
	end

	// rows of Rx*Ry in Q.28
	always_comb begin
		a0_d[0] = PW'(c_r[1]) <<< 14;
		a1_d[0] = '0;
		a2_d[0] = -(PW'(s_r[1]) <<< 14);
		a0_d[1] = PW'(s_r[0] * s_r[1]);
		a1_d[1] = PW'(c_r[0]) <<< 14;
		a2_d[1] = PW'(s_r[0] * c_r[1]);
		a0_d[2] = PW'(c_r[0] * s_r[1]);
		a1_d[2] = -(PW'(s_r[0]) <<< 14);
		a2_d[2] = PW'(c_r[0] * c_r[1]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				a0_p1[r] <= a0_d[r];
				a1_p1[r] <= a1_d[r];
				a2_p1[r] <= a2_d[r];
			end
			sz_p1 <= s_r[2];
			cz_p1 <= c_r[2];
		end
	end

	// Q.28 times Q.14 lands directly in Q.42
	always_ff @(posedge clk) begin
		logic signed [PW+ENT_W-1:0] m0;
		logic signed [PW+ENT_W-1:0] m1;
		logic signed [PW+ENT_W-1:0] m2;
		logic signed [PW+ENT_W-1:0] m3;
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				m0 = a0_p1[r] * cz_p1;
				m1 = a1_p1[r] * sz_p1;
				m2 = a0_p1[r] * sz_p1;
				m3 = a1_p1[r] * cz_p1;
				t_p2[r][0] <= QW'(m0);
				t_p2[r][1] <= QW'(m1);
				t_p2[r][2] <= QW'(m2);
				t_p2[r][3] <= QW'(m3);
				a2_p2[r]   <= a2_p1[r];
			end
		end
	end

	always_comb begin
		res_d.e00 = finish(t_p2[0][0] - t_p2[0][1]);
		res_d.e01 = finish(t_p2[0][2] + t_p2[0][3]);
		res_d.e02 = finish(QW'(a2_p2[0]) <<< 14);
		res_d.e10 = finish(t_p2[1][0] - t_p2[1][1]);
		res_d.e11 = finish(t_p2[1][2] + t_p2[1][3]);
		res_d.e12 = finish(QW'(a2_p2[1]) <<< 14);
		res_d.e20 = finish(t_p2[2][0] - t_p2[2][1]);
		res_d.e21 = finish(t_p2[2][2] + t_p2[2][3]);
		res_d.e22 = finish(QW'(a2_p2[2]) <<< 14);
	end

	// result queue
	always_ff @(posedge clk) begin
		if (opush)
			obuf_q[owp_q] <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (opush)
				owp_q <= !owp_q;
			if (odo_pop)
				orp_q <= !orp_q;
			if (opush && !odo_pop)
				ocnt_q <= ocnt_q + 2'd1;
			else if (odo_pop && !opush)
				ocnt_q <= ocnt_q - 2'd1;
		end
	end

`ifndef SYNTHESIS
	a_ocnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= 2'd2) else $error("result queue count out of range");
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(odo_pop && !opush) |=> (ocnt_q == $past(ocnt_q) - 2'd1))
		else $error("result queue count did not drop on pop");
	a_pull_enters: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> v_q[0]) else $error("pulled item did not enter the pipeline");
	a_entry_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (mat.e00 <= 16'sd16384 && mat.e00 >= -16'sd16384))
		else $error("matrix entry beyond one");
`endif

endmodule

`default_nettype wire
